@@ rtl/cpf_pkg.sv @@
// shared types, constants and crc helpers for the command packet framer
package cpf_pkg;

  localparam int unsigned FRAME_LEN   = 12;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FRAME_W     = FRAME_LEN * BYTE_W;
  localparam int unsigned CNT_W       = $clog2(FRAME_LEN);
  localparam int unsigned PACKED_LEN  = 9;
  localparam int unsigned PACK_W      = 7;
  localparam int unsigned PAYLOAD_W   = 64;
  localparam int unsigned CRC_BYTES   = 6;

  localparam logic [7:0]       HEADER_BYTE = 8'hFF;
  localparam logic [15:0]      CRC_POLY    = 16'hA001;
  localparam logic [CNT_W-1:0] LAST_IDX    = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] FIRST_DATA  = CNT_W'(2);

  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;

  // one byte through crc-16/arc, lsb first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/cpf_req_if.sv @@
// request channel: command code and two arguments
interface cpf_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command_code;
  logic [15:0] first_argument;
  logic [15:0] second_argument;

  modport source(output valid, output command_code, output first_argument,
                 output second_argument, input ready);
  modport sink(input valid, input command_code, input first_argument,
               input second_argument, output ready);
endinterface

@@ rtl/cpf_byte_if.sv @@
// frame byte channel
interface cpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source(output valid, output frame_byte, output last_byte, input ready);
  modport sink(input valid, input frame_byte, input last_byte, output ready);
endinterface

@@ rtl/cpf_encode.sv @@
// request register and single-pass frame builder (crc and 7-bit packing)
module cpf_encode (
  input  logic             clk,
  input  logic             rst,
  cpf_req_if.sink          req,
  input  logic [7:0]       device_address,
  output logic             frame_valid,
  input  logic             frame_ready,
  output cpf_pkg::frame_t  frame
);

  logic        held;
  logic [7:0]  cmd;
  logic [15:0] arg1;
  logic [15:0] arg2;

  logic [15:0]        crc;
  cpf_pkg::payload_t  bits;
  logic [7:0]         crc_bytes [cpf_pkg::CRC_BYTES];

  // slot frees when the serializer takes the held request
  assign req.ready   = !held || frame_ready;
  assign frame_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req.ready) begin
      held <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd  <= req.command_code;
      arg1 <= req.first_argument;
      arg2 <= req.second_argument;
    end
  end

  always_comb begin
    crc_bytes[0] = device_address;
    crc_bytes[1] = cmd;
    crc_bytes[2] = arg1[7:0];
    crc_bytes[3] = arg1[15:8];
    crc_bytes[4] = arg2[7:0];
    crc_bytes[5] = arg2[15:8];
    crc = 16'h0000;
    for (int i = 0; i < cpf_pkg::CRC_BYTES; i++) begin
      crc = cpf_pkg::crc16_update(crc, crc_bytes[i]);
    end
    bits = {device_address, cmd, arg1[7:0], arg1[15:8], arg2[7:0], arg2[15:8],
            crc[7:0], crc[15:8]};
  end

  // header, nine 7-bit groups msb first, then the leftover bit at position 6
  always_comb begin
    frame[cpf_pkg::FRAME_W-1 -: 8]  = cpf_pkg::HEADER_BYTE;
    frame[cpf_pkg::FRAME_W-9 -: 8]  = cpf_pkg::HEADER_BYTE;
    for (int k = 0; k < cpf_pkg::PACKED_LEN; k++) begin
      frame[cpf_pkg::FRAME_W-17-8*k -: 8] =
        {1'b0, bits[cpf_pkg::PAYLOAD_W-1-cpf_pkg::PACK_W*k -: cpf_pkg::PACK_W]};
    end
    frame[7:0] = {1'b0, bits[0], 6'b000000};
  end

endmodule

@@ rtl/cpf_serialize.sv @@
// frame shift register that hands out one byte per beat
module cpf_serialize (
  input  logic            clk,
  input  logic            rst,
  input  logic            frame_valid,
  output logic            frame_ready,
  input  cpf_pkg::frame_t frame,
  cpf_byte_if.source      tx
);

  logic                      busy;
  logic [cpf_pkg::CNT_W-1:0] cnt;
  cpf_pkg::frame_t           shreg;
  logic                      at_last;

  assign at_last       = (cnt == cpf_pkg::LAST_IDX);
  assign frame_ready   = !busy || (tx.ready && at_last);
  assign tx.valid      = busy;
  assign tx.frame_byte = shreg[cpf_pkg::FRAME_W-1 -: 8];
  assign tx.last_byte  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (frame_valid && frame_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && tx.ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      shreg <= frame;
    end else if (busy && tx.ready) begin
      shreg <= {shreg[cpf_pkg::FRAME_W-9:0], 8'h00};
    end
  end

`ifndef SYNTHESIS
  // the first beat of every frame is a header byte
  a_header: assert property (@(posedge clk) disable iff (rst)
    busy && (cnt == '0) |-> tx.frame_byte == cpf_pkg::HEADER_BYTE)
    else $error("frame does not open with header byte");

  // packed beats never carry the top bit
  a_packed_7bit: assert property (@(posedge clk) disable iff (rst)
    busy && (cnt >= cpf_pkg::FIRST_DATA) |-> !tx.frame_byte[7])
    else $error("packed byte has bit 7 set");

  // a waiting frame follows the last beat with no gap
  a_back_to_back: assert property (@(posedge clk) disable iff (rst)
    busy && tx.ready && at_last && frame_valid |=> busy && (cnt == '0))
    else $error("gap between consecutive frames");
`endif

endmodule

@@ rtl/command_packet_framer_crc16_7bit_top.sv @@
// top level of the command packet framer with crc-16 and 7-bit packing
// Command packet framer. Each request beat on req (command code and two
// 16-bit arguments) becomes a 12-beat frame on tx: two 0xff header bytes,
// then the 64-bit payload {device_address, command_code, first_argument
// little-endian, second_argument little-endian, crc-16/arc low, high} cut
// msb first into nine 7-bit bytes, then a tail byte holding the final
// payload bit at bit 6. last_byte marks the twelfth beat. The output
// shift register hands out one beat per cycle while tx is ready; the
// next request is held in the input register meanwhile, so with tx always
// ready frames stream back to back. A request passes through the input
// register and then the output shift register before its first byte
// appears. device_address is written through cfg_we/cfg_wdata, resets to
// 0 and should change only while the block is idle.
module command_packet_framer_crc16_7bit_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  cpf_req_if.sink    req,
  cpf_byte_if.source tx
);

  // device address register, first payload byte
  logic [7:0] device_address;

  // encoder to serializer handoff
  logic            frame_valid;
  logic            frame_ready;
  cpf_pkg::frame_t frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'h00;
    end else if (cfg_we) begin
      device_address <= cfg_wdata;
    end
  end

  // request register plus crc and packing logic
  cpf_encode u_encode (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .device_address (device_address),
    .frame_valid    (frame_valid),
    .frame_ready    (frame_ready),
    .frame          (frame)
  );

  // byte-wide output shift register
  cpf_serialize u_serialize (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .tx          (tx)
  );

endmodule
